FILE: rtl/tli_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the table linear interpolator.
// No dependencies; the other files of the block, apart from tli_ram, refer to it by scoped names.
package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;   // default number of breakpoints
    localparam int XW              = 32;   // Q16.16 value width
    localparam int IDX_W           = 6;    // entry_index field width
    localparam int CFG_W           = 7;    // points_in_use register width
    localparam int FRAC_W          = 16;   // fraction bits of t
    localparam int T_W             = FRAC_W + 1;   // t spans 0 .. one inclusive
    localparam int S_TDATA_W       = 104;  // 102 payload bits padded to bytes
    localparam int M_TDATA_W       = 32;
    localparam int CFG_RESET       = 2;
    localparam int MIN_POINTS      = 2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap_in;      // capture query point and clamped point count
        logic load;        // write one breakpoint
        logic rd_first;    // read entry 0
        logic rd_last;     // read entry n-1, capture first abscissa
        logic check;       // decide range, init search
        logic probe;       // read the search probe
        logic cmp;         // narrow the search window
        logic rd_lo;       // clamp index, read entry i-1
        logic rd_hi;       // capture entry i-1, read entry i
        logic cap_hi;      // capture entry i, form numerator/span/difference
        logic prep;        // resolve the trivial fractions
        logic div_start;   // launch the fraction divider
        logic div_take;    // take the divider quotient
        logic mul;         // multiply the difference by the fraction
        logic sum;         // add the base ordinate
        logic out_load;    // move the result into the output register
    } tli_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_span;
        logic cnt_zero;
        logic prep_direct;
        logic div_done;
        logic out_busy;
    } tli_status_t;

endpackage

FILE: rtl/tli_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tli_div.sv
`timescale 1ns / 1ps
// Restoring divider for the interpolation fraction: floor(num * 2^16 / den), num < den.
// Depends on tli_pkg for widths.
module tli_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tli_pkg::XW-1:0]    num,
    input  logic [tli_pkg::XW-1:0]    den,
    output logic [tli_pkg::FRAC_W-1:0] quo,
    output logic                      done
);

    localparam int CNT_W = $clog2(tli_pkg::FRAC_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tli_pkg::XW-1:0]     rem_reg, rem_next;
    logic [tli_pkg::XW-1:0]     den_reg, den_next;
    logic [tli_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [tli_pkg::XW:0]       rem_sh;
    logic [tli_pkg::XW:0]       rem_sub;
    logic                       ge;

    always_comb
    begin
        rem_sh    = {rem_reg, 1'b0};
        rem_sub   = rem_sh - {1'b0, den_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle; remainder always stays below den
            rem_next = ge ? rem_sub[tli_pkg::XW-1:0] : rem_sh[tli_pkg::XW-1:0];
            quo_next = {quo_reg[tli_pkg::FRAC_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(tli_pkg::FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

FILE: rtl/tli_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the interpolator: load, range check, search, divide, blend.
// Depends on tli_pkg for the command and status structs.
module tli_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    input  tli_pkg::tli_status_t status,
    output tli_pkg::tli_cmd_t    cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_RD_FIRST = 14'b00000000000010,
        S_RD_LAST  = 14'b00000000000100,
        S_CHECK    = 14'b00000000001000,
        S_PROBE    = 14'b00000000010000,
        S_CMP      = 14'b00000000100000,
        S_FIX      = 14'b00000001000000,
        S_RD_LO    = 14'b00000010000000,
        S_RD_HI    = 14'b00000100000000,
        S_PREP     = 14'b00001000000000,
        S_DIV      = 14'b00010000000000,
        S_MUL      = 14'b00100000000000,
        S_SUM      = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    if (in_mode)
                    begin
                        state_next = S_RD_FIRST;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_RD_FIRST:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.in_span ? S_PROBE : S_OUT;
            end
            S_PROBE:
            begin
                if (status.cnt_zero)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_PROBE;
            end
            S_FIX:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (status.prep_direct)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/tli_dp.sv
`timescale 1ns / 1ps
// Datapath of the interpolator: breakpoint RAM, search window, divider, blend, output register.
// Depends on tli_pkg, tli_ram and tli_div.
module tli_dp #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tli_pkg::tli_cmd_t             cmd,
    output tli_pkg::tli_status_t          status,
    input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          cfg_we,
    input  logic [tli_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [tli_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = tli_pkg::XW;
    localparam int RW = 2 * XW;

    // input fields
    logic [tli_pkg::IDX_W-1:0] in_idx;
    logic [XW-1:0]             in_x, in_y, in_q;

    assign in_idx = s_tdata[5:0];
    assign in_x   = s_tdata[37:6];
    assign in_y   = s_tdata[69:38];
    assign in_q   = s_tdata[101:70];

    // configuration
    logic [tli_pkg::CFG_W-1:0] cfg_reg;
    logic [CW-1:0]             n_eff;

    always_comb
    begin
        if (cfg_reg < tli_pkg::CFG_W'(tli_pkg::MIN_POINTS))
        begin
            n_eff = CW'(tli_pkg::MIN_POINTS);
        end
        else if (32'(cfg_reg) > 32'(TABLE_DEPTH))
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(cfg_reg);
        end
    end

    // working registers
    logic signed [XW-1:0] q_reg, first_reg, x0_reg, y0_reg;
    logic [CW-1:0]        n_reg, lo_reg, cnt_reg, probe_reg, step_reg, i_reg;
    logic signed [XW:0]   num_reg, den_reg, diff_reg;
    logic [tli_pkg::T_W-1:0] t_reg;
    logic signed [XW+tli_pkg::T_W+1:0] prod_reg;
    logic [XW-1:0]        res_reg;
    logic                 range_reg;

    logic                 out_valid_reg;
    logic [XW-1:0]        out_data_reg;
    logic                 out_range_reg;

    // RAM: ordinate in the upper half, abscissa in the lower half
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_rdata;
    logic signed [XW-1:0] rd_x, rd_y;

    assign rd_x = signed'(ram_rdata[XW-1:0]);
    assign rd_y = signed'(ram_rdata[RW-1:XW]);

    assign ram_we    = cmd.load && (32'(in_idx) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(in_idx);

    // search arithmetic
    logic [CW-1:0] step_c, probe_c, n_m1, i_c, i_m1;

    always_comb
    begin
        step_c  = cnt_reg >> 1;
        probe_c = lo_reg + step_c;
        n_m1    = n_reg - CW'(1);
        if (lo_reg == '0)
        begin
            i_c = CW'(1);
        end
        else if (lo_reg > n_m1)
        begin
            i_c = n_m1;
        end
        else
        begin
            i_c = lo_reg;
        end
        i_m1 = i_c - CW'(1);
    end

    always_comb
    begin
        ram_re    = cmd.rd_first | cmd.rd_last | cmd.probe | cmd.rd_lo | cmd.rd_hi;
        ram_raddr = '0;
        if (cmd.rd_last)
        begin
            ram_raddr = n_m1[AW-1:0];
        end
        else if (cmd.probe)
        begin
            ram_raddr = probe_c[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            ram_raddr = i_m1[AW-1:0];
        end
        else if (cmd.rd_hi)
        begin
            ram_raddr = i_reg[AW-1:0];
        end
    end

    tli_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_y, in_x}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fraction divider
    logic [tli_pkg::FRAC_W-1:0] div_quo;
    logic                       div_done;

    tli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg[XW-1:0]),
        .den   (den_reg[XW-1:0]),
        .quo   (div_quo),
        .done  (div_done)
    );

    logic in_span_c, prep_direct_c;

    assign in_span_c     = (q_reg > first_reg) && (q_reg <= rd_x);
    assign prep_direct_c = num_reg[XW] || (den_reg <= 0) || (num_reg >= den_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            q_reg <= signed'(in_q);
            n_reg <= n_eff;
        end
        if (cmd.rd_last)
        begin
            first_reg <= rd_x;
        end
        if (cmd.check)
        begin
            lo_reg    <= '0;
            cnt_reg   <= n_reg;
            res_reg   <= '0;
            range_reg <= in_span_c;
        end
        if (cmd.probe)
        begin
            probe_reg <= probe_c;
            step_reg  <= step_c;
        end
        if (cmd.cmp)
        begin
            if (rd_x < q_reg)
            begin
                lo_reg  <= probe_reg + CW'(1);
                cnt_reg <= cnt_reg - step_reg - CW'(1);
            end
            else
            begin
                cnt_reg <= step_reg;
            end
        end
        if (cmd.rd_lo)
        begin
            i_reg <= i_c;
        end
        if (cmd.rd_hi)
        begin
            x0_reg <= rd_x;
            y0_reg <= rd_y;
        end
        if (cmd.cap_hi)
        begin
            num_reg  <= {q_reg[XW-1], q_reg} - {x0_reg[XW-1], x0_reg};
            den_reg  <= {rd_x[XW-1], rd_x} - {x0_reg[XW-1], x0_reg};
            diff_reg <= {rd_y[XW-1], rd_y} - {y0_reg[XW-1], y0_reg};
        end
        if (cmd.prep && prep_direct_c)
        begin
            // negative numerator pins t to zero; otherwise the fraction is one
            t_reg <= num_reg[XW] ? '0 : {1'b1, {tli_pkg::FRAC_W{1'b0}}};
        end
        if (cmd.div_take)
        begin
            t_reg <= {1'b0, div_quo};
        end
        if (cmd.mul)
        begin
            prod_reg <= diff_reg * signed'({1'b0, t_reg});
        end
        if (cmd.sum)
        begin
            // y0 + floor(diff * t / 2^16); the sum always fits 32 bits
            res_reg <= y0_reg + prod_reg[XW+tli_pkg::FRAC_W-1:tli_pkg::FRAC_W];
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= res_reg;
            out_range_reg <= range_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= tli_pkg::CFG_W'(tli_pkg::CFG_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.in_span     = in_span_c;
        status.cnt_zero    = (cnt_reg == '0);
        status.prep_direct = prep_direct_c;
        status.div_done    = div_done;
        status.out_busy    = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_range_reg;

endmodule

FILE: rtl/table_linear_interpolator.sv
`timescale 1ns / 1ps
// Top level of the piecewise linear interpolator over a breakpoint table.
// Depends on tli_pkg, tli_ctrl and tli_dp (which holds tli_ram and tli_div).
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tuser: mode; tdata: index, x, y, query
//  m_*      | out | m_tvalid/m_tready | tuser: in_range; tdata: interpolated
//  cfg_*    | in  | cfg_we            | cfg_data: points_in_use
//
// A load transfer writes its breakpoint directly and s_tready stays high. A query outside
// the span (at or below the first breakpoint, or above the last one in use) goes
// straight from the range check to the output. Inside the span it runs up to
// ceil(log2(n+1)) search probes, each a RAM read and a compare, then the bit-serial
// divider; a fraction of zero or one skips the divider.
// The single read port of the breakpoint RAM sets the search pace.
// Reset is asynchronous, active low; points_in_use returns to 2, table contents are
// undefined until written. A finished result waits in the output register while the
// next transfer is taken; the block stalls only when a second result is ready first.
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,   // entry_index, entry_abscissa,
                                                     // entry_ordinate, query_point, pad
    input  logic                          s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tli_pkg::M_TDATA_W-1:0] m_tdata,   // interpolated
    output logic                          m_tuser,   // in_range
    input  logic                          cfg_we,
    input  logic [tli_pkg::CFG_W-1:0]     cfg_data   // points_in_use
);

    tli_pkg::tli_cmd_t    cmd;
    tli_pkg::tli_status_t status;

    // sequence each transfer; commands advance the datapath one step at a time
    tli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the table, run the search, divide and blend, drive the result
    tli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/tli_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the interpolator, bound to the top level.
// Depends on tli_pkg for port widths.
module tli_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tli_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an out-of-range answer is zero
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out-of-range result not zero");

    // a query transfer occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready after query transfer");

    // a load transfer leaves the block ready in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("not ready after load transfer");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
